FILE: hdl/oaht_pkg.sv
// Shared types and codes for the open-address hash table.
package oaht_pkg;

    typedef enum logic [1:0] {
        MODE_GET = 2'd0,
        MODE_SET = 2'd1,
        MODE_DEL = 2'd2,
        MODE_POP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } oaht_in_t;

    typedef struct packed {
        status_t     status;
        logic        new_key;
        logic [63:0] value_out;
    } oaht_out_t;

    localparam int unsigned CFG_BITS = 8;
    localparam logic [CFG_BITS-1:0] MAX_OCC_RESET = 8'd192;

endpackage

FILE: hdl/open_address_hash_table.sv
// Key/value map with linear probing, tombstones and a fixed slot store.
//
// Each word on s_data is a get, set, delete or pop; exactly one result word
// comes back on m_data. The tag and key of every slot share one synchronous
// memory and the values sit in a second one; both are read at the same probe
// address. An item is taken in, then its slots are probed one after another
// through that read port, from 1 up to SLOTS of them, and an item also waits
// while m_ready holds back the previous result. Only one item is in flight;
// the next word is taken the cycle after the result is registered. After
// reset the tag memory is swept to empty, one slot per cycle, and s_ready
// stays low until the sweep is done; configuration writes are taken at any
// time. New keys are refused with a full status once the count of live and
// tombstoned slots reaches max_reg, or when no free slot is found.
module open_address_hash_table
    import oaht_pkg::*;
#(
    parameter int unsigned SLOTS      = 256,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oaht_in_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output oaht_out_t           m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    localparam int unsigned SLOT_BITS = $clog2(SLOTS);
    localparam int unsigned TK_BITS   = KEY_BITS + 2;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    // tag and key memory, value memory
    logic [TK_BITS-1:0]    tk_mem  [SLOTS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS];

    logic [TK_BITS-1:0]    tk_q;
    logic [VALUE_BITS-1:0] val_q;
    logic [SLOT_BITS-1:0]  rd_addr;

    logic                  tk_we;
    logic [SLOT_BITS-1:0]  tk_waddr;
    logic [TK_BITS-1:0]    tk_wdata;
    logic                  val_we;
    logic [SLOT_BITS-1:0]  val_waddr;

    state_t                state_reg, state_next;
    mode_t                 mode_reg, mode_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SLOT_BITS-1:0]  idx_reg, idx_next;
    logic [SLOT_BITS-1:0]  cnt_reg, cnt_next;
    logic [SLOT_BITS-1:0]  tomb_reg, tomb_next;
    logic                  have_tomb_reg, have_tomb_next;
    logic [SLOT_BITS-1:0]  clr_reg, clr_next;
    logic [CFG_BITS-1:0]   occ_reg, occ_next;
    logic [CFG_BITS-1:0]   max_reg, max_next;
    logic                  m_valid_reg, m_valid_next;
    oaht_out_t             out_reg, out_next;

    // probe outcome
    tag_t                  cur_tag;
    logic                  key_hit;
    logic                  done;
    logic                  found;
    logic                  ok;
    logic [SLOT_BITS-1:0]  slot;
    logic                  slot_empty;
    logic                  out_free;
    logic                  finish;
    logic                  s_take;

    assign cur_tag   = tag_t'(tk_q[TK_BITS-1 -: 2]);
    assign key_hit   = (tk_q[KEY_BITS-1:0] == key_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign rd_addr   = idx_next;

    // memories
    always_ff @(posedge aclk) begin
        if (tk_we) begin
            tk_mem[tk_waddr] <= tk_wdata;
        end
        tk_q <= tk_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_waddr] <= val_reg;
        end
        val_q <= val_mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_take) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // probe decision
    always_comb begin
        done       = 1'b0;
        found      = 1'b0;
        ok         = 1'b0;
        slot       = have_tomb_reg ? tomb_reg : idx_reg;
        slot_empty = 1'b0;
        case (cur_tag)
            TAG_EMPTY: begin
                done       = 1'b1;
                ok         = 1'b1;
                slot_empty = !have_tomb_reg;
            end
            TAG_LIVE: begin
                if (key_hit) begin
                    done  = 1'b1;
                    found = 1'b1;
                    ok    = 1'b1;
                    slot  = idx_reg;
                end else begin
                    done = (cnt_reg == LAST_SLOT);
                    ok   = have_tomb_reg;
                end
            end
            default: begin
                // tombstone: the last slot seen may be the first tombstone
                done = (cnt_reg == LAST_SLOT);
                ok   = 1'b1;
            end
        endcase
        finish = (state_reg == ST_PROBE) && done && out_free;
    end

    // datapath and memory writes
    always_comb begin
        mode_next      = mode_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        tomb_next      = tomb_reg;
        have_tomb_next = have_tomb_reg;
        clr_next       = clr_reg;
        occ_next       = occ_reg;
        max_next       = max_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        tk_we          = 1'b0;
        tk_waddr       = slot;
        tk_wdata       = {TAG_LIVE, key_reg};
        val_we         = 1'b0;
        val_waddr      = slot;

        if (cfg_valid) begin
            max_next = cfg_wdata;
        end

        case (state_reg)
            ST_CLEAR: begin
                tk_we    = 1'b1;
                tk_waddr = clr_reg;
                tk_wdata = {TAG_EMPTY, {KEY_BITS{1'b0}}};
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_take) begin
                    mode_next      = s_data.mode;
                    key_next       = KEY_BITS'(s_data.key_id);
                    val_next       = VALUE_BITS'(s_data.value_in);
                    idx_next       = s_data.key_hash[SLOT_BITS-1:0];
                    cnt_next       = '0;
                    have_tomb_next = 1'b0;
                end
            end
            ST_PROBE: begin
                if (!done) begin
                    if (cur_tag == TAG_TOMB && !have_tomb_reg) begin
                        have_tomb_next = 1'b1;
                        tomb_next      = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end else if (finish) begin
                    m_valid_next      = 1'b1;
                    out_next.new_key  = 1'b0;
                    out_next.value_out = '0;
                    out_next.status   = STATUS_MISSING;
                    if (mode_reg == MODE_SET) begin
                        if (found) begin
                            val_we          = 1'b1;
                            out_next.status = STATUS_OK;
                        end else if (!ok || occ_reg >= max_reg) begin
                            out_next.status = STATUS_FULL;
                        end else begin
                            tk_we            = 1'b1;
                            val_we           = 1'b1;
                            out_next.status  = STATUS_OK;
                            out_next.new_key = 1'b1;
                            if (slot_empty) begin
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                    end else if (found) begin
                        out_next.status = STATUS_OK;
                        if (mode_reg == MODE_GET || mode_reg == MODE_POP) begin
                            out_next.value_out = 64'(val_q);
                        end
                        if (mode_reg == MODE_DEL || mode_reg == MODE_POP) begin
                            tk_we    = 1'b1;
                            tk_wdata = {TAG_TOMB, key_reg};
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            occ_reg     <= '0;
            max_reg     <= MAX_OCC_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            occ_reg     <= occ_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        tomb_reg      <= tomb_next;
        have_tomb_reg <= have_tomb_next;
        out_reg       <= out_next;
    end

endmodule
